// ----- rtl/sdf_primitive_with_gradient_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the signed distance block
// Checks compile in simulation; under synthesis the macros expand to nothing.
// ----------------------------------------------------------------------------
`ifndef SDF_PRIMITIVE_WITH_GRADIENT_MACROS_SVH
`define SDF_PRIMITIVE_WITH_GRADIENT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, clocked on clk and disabled in reset.
`define SDFP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sdfp assertion failed");
// Next-cycle implication, clocked on clk and disabled in reset.
`define SDFP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sdfp assertion failed");
`else
`define SDFP_ASSERT_IMP(lbl, ante, cons)
`define SDFP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/sdfp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdfp_pkg
// Shared types, widths and fixed-point constants of the distance block.
// ----------------------------------------------------------------------------
package sdfp_pkg;

  // Field widths.
  localparam int COORD_W = 25;   // sample coordinate, input plus step
  localparam int MAG_W   = 24;   // magnitude of a sample coordinate
  localparam int DIST_W  = 27;   // internal signed distance
  localparam int DIFF_W  = 16;   // central difference
  localparam int LEN_W   = 17;   // gradient length
  localparam int Q_W     = 15;   // quotient of one gradient component
  localparam int REM_W   = 18;   // divider remainder

  // Root or quotient steps done in one pipeline stage.
  localparam int SQRT_STEPS_DEF = 2;

  // Primitive codes.
  typedef enum logic [1:0] {
    SHAPE_SPHERE = 2'd0,
    SHAPE_BOX    = 2'd1,
    SHAPE_TORUS  = 2'd2,
    SHAPE_CYL    = 2'd3
  } shape_t;

  // Sample positions around the point.
  localparam int SMP_CENTER = 0;
  localparam int SMP_XP     = 1;
  localparam int SMP_COUNT  = 7;

  // Shape constants, Q.16.
  localparam logic signed [DIST_W-1:0] K_R_SPHERE  = 27'sd196608;
  localparam logic signed [DIST_W-1:0] K_BOX_HALF  = 27'sd157286;
  localparam logic signed [DIST_W-1:0] K_BOX_ROUND = 27'sd26214;
  localparam logic signed [DIST_W-1:0] K_TOR_MAJOR = 27'sd163840;
  localparam logic signed [DIST_W-1:0] K_TOR_MINOR = 27'sd65536;
  localparam logic signed [DIST_W-1:0] K_CYL_RAD   = 27'sd131072;
  localparam logic signed [DIST_W-1:0] K_CYL_HALF  = 27'sd170394;
  localparam logic signed [COORD_W-1:0] K_STEP     = 25'sd3277;
  localparam logic signed [DIST_W-1:0] DIST_MAX    = 27'sd16777215;
  localparam logic signed [DIST_W-1:0] DIST_MIN    = -27'sd16777216;

  // One input beat.
  typedef struct packed {
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] point_z;
  } point_t;

  // One result beat.
  typedef struct packed {
    logic signed [24:0] distance;
    logic signed [15:0] grad_x;
    logic signed [15:0] grad_y;
    logic signed [15:0] grad_z;
    logic               is_outside;
  } result_t;

  // Magnitude of a sample coordinate.
  function automatic logic [MAG_W-1:0] coord_mag(input logic signed [COORD_W-1:0] v);
    logic [COORD_W-1:0] t;
    t = v[COORD_W-1] ? -v : v;
    return t[MAG_W-1:0];
  endfunction

  // Magnitude of a central difference; the most negative code maps to 2^15.
  function automatic logic [DIFF_W-1:0] diff_mag(input logic signed [DIFF_W-1:0] v);
    logic [DIFF_W-1:0] t;
    t = v[DIFF_W-1] ? -v : v;
    return t;
  endfunction

endpackage

// ----- rtl/sdfp_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdfp_sqrt
// Pipelined floor square root, restoring digit by digit, a few root bits per
// stage. Side data and a valid bit travel alongside the radicand.
// ----------------------------------------------------------------------------
module sdfp_sqrt #(
  parameter int RAD_W  = 50,
  parameter int SIDE_W = 1,
  parameter int STEPS  = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [RAD_W-1:0]    radicand,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output logic [RAD_W/2-1:0]  root,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int RW     = RAD_W / 2;
  localparam int REMW   = RW + 3;
  localparam int STAGES = (RW + STEPS - 1) / STEPS;

  logic              vld_q  [STAGES];
  logic [REMW-1:0]   rem_q  [STAGES];
  logic [RW-1:0]     root_q [STAGES];
  logic [RAD_W-1:0]  rad_q  [STAGES];
  logic [SIDE_W-1:0] side_q [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic              vld_in;
    logic [REMW-1:0]   rem_in;
    logic [RW-1:0]     root_in;
    logic [RAD_W-1:0]  rad_in;
    logic [SIDE_W-1:0] side_in;
    logic [REMW-1:0]   rem_c;
    logic [RW-1:0]     root_c;
    logic [RAD_W-1:0]  rad_c;
    logic [REMW-1:0]   trial;

    // Stage inputs come from the ports or from the stage before.
    if (s == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = radicand;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
      assign side_in = side_q[s-1];
    end

    // Each step brings down two radicand bits and decides one root bit.
    always_comb begin
      rem_c  = rem_in;
      root_c = root_in;
      rad_c  = rad_in;
      trial  = '0;
      for (int k = 0; k < STEPS; k++) begin
        if (s * STEPS + k < RW) begin
          rem_c = {rem_c[REMW-3:0], rad_c[RAD_W-1 -: 2]};
          rad_c = {rad_c[RAD_W-3:0], 2'b00};
          trial = {1'b0, root_c, 2'b01};
          if (rem_c >= trial) begin
            rem_c  = rem_c - trial;
            root_c = {root_c[RW-2:0], 1'b1};
          end else begin
            root_c = {root_c[RW-2:0], 1'b0};
          end
        end
      end
    end

    // Valid is cleared by reset; the payload only follows the enable.
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (en) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s]  <= rem_c;
        root_q[s] <= root_c;
        rad_q[s]  <= rad_c;
        side_q[s] <= side_in;
      end
    end
  end

  assign out_valid = vld_q[STAGES-1];
  assign root      = root_q[STAGES-1];
  assign out_side  = side_q[STAGES-1];

endmodule

// ----- rtl/sdfp_norm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdfp_norm
// Three pipelined restoring dividers that scale the central differences to
// unit length, followed by the result register with distance saturation.
// ----------------------------------------------------------------------------
module sdfp_norm #(
  parameter int STEPS = 2
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         en,
  input  logic                                         in_valid,
  input  logic [sdfp_pkg::LEN_W-1:0]                   len,
  input  logic [2:0][sdfp_pkg::DIFF_W-1:0]             mags,
  input  logic [2:0]                                   signs,
  input  logic signed [sdfp_pkg::DIST_W-1:0]           sdist,
  output logic                                         out_valid,
  output sdfp_pkg::result_t                            result
);

  import sdfp_pkg::*;

  localparam int STAGES = (Q_W + STEPS - 1) / STEPS;

  logic                     vld_q  [STAGES];
  logic [LEN_W-1:0]         div_q  [STAGES];
  logic [2:0]               sgn_q  [STAGES];
  logic signed [DIST_W-1:0] dist_q [STAGES];
  logic [REM_W-1:0]         rem_q  [STAGES][3];
  logic [Q_W-1:0]           nb_q   [STAGES][3];
  logic [Q_W-1:0]           quo_q  [STAGES][3];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic                     vld_in;
    logic [LEN_W-1:0]         div_in;
    logic [2:0]               sgn_in;
    logic signed [DIST_W-1:0] dist_in;
    logic [REM_W-1:0]         rem_in [3];
    logic [Q_W-1:0]           nb_in  [3];
    logic [Q_W-1:0]           quo_in [3];
    logic [REM_W-1:0]         rem_c  [3];
    logic [Q_W-1:0]           nb_c   [3];
    logic [Q_W-1:0]           quo_c  [3];

    // The first stage starts each lane with the magnitude less its low bit.
    if (s == 0) begin : g_first
      assign vld_in  = in_valid;
      assign div_in  = len;
      assign sgn_in  = signs;
      assign dist_in = sdist;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_in[l] = {{(REM_W-DIFF_W+1){1'b0}}, mags[l][DIFF_W-1:1]};
        assign nb_in[l]  = {mags[l][0], {(Q_W-1){1'b0}}};
        assign quo_in[l] = '0;
      end
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign div_in  = div_q[s-1];
      assign sgn_in  = sgn_q[s-1];
      assign dist_in = dist_q[s-1];
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_in[l] = rem_q[s-1][l];
        assign nb_in[l]  = nb_q[s-1][l];
        assign quo_in[l] = quo_q[s-1][l];
      end
    end

    // One quotient bit per step in each lane.
    always_comb begin
      for (int l = 0; l < 3; l++) begin
        rem_c[l] = rem_in[l];
        nb_c[l]  = nb_in[l];
        quo_c[l] = quo_in[l];
      end
      for (int k = 0; k < STEPS; k++) begin
        if (s * STEPS + k < Q_W) begin
          for (int l = 0; l < 3; l++) begin
            rem_c[l] = {rem_c[l][REM_W-2:0], nb_c[l][Q_W-1]};
            nb_c[l]  = {nb_c[l][Q_W-2:0], 1'b0};
            if (rem_c[l] >= {1'b0, div_in}) begin
              rem_c[l] = rem_c[l] - {1'b0, div_in};
              quo_c[l] = {quo_c[l][Q_W-2:0], 1'b1};
            end else begin
              quo_c[l] = {quo_c[l][Q_W-2:0], 1'b0};
            end
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else if (en) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        div_q[s]  <= div_in;
        sgn_q[s]  <= sgn_in;
        dist_q[s] <= dist_in;
        for (int l = 0; l < 3; l++) begin
          rem_q[s][l] <= rem_c[l];
          nb_q[s][l]  <= nb_c[l];
          quo_q[s][l] <= quo_c[l];
        end
      end
    end
  end

  // Final signs, zero-length gradient and distance saturation.
  logic [DIFF_W-1:0]        comp [3];
  logic signed [DIST_W-1:0] dlast;
  result_t                  res_next;

  always_comb begin
    dlast = dist_q[STAGES-1];
    for (int l = 0; l < 3; l++) begin
      if (div_q[STAGES-1] == '0) begin
        comp[l] = '0;
      end else if (sgn_q[STAGES-1][l]) begin
        comp[l] = -{1'b0, quo_q[STAGES-1][l]};
      end else begin
        comp[l] = {1'b0, quo_q[STAGES-1][l]};
      end
    end
    res_next.grad_x = comp[0];
    res_next.grad_y = comp[1];
    res_next.grad_z = comp[2];
    if (dlast > DIST_MAX) begin
      res_next.distance = DIST_MAX[24:0];
    end else if (dlast < DIST_MIN) begin
      res_next.distance = DIST_MIN[24:0];
    end else begin
      res_next.distance = dlast[24:0];
    end
    res_next.is_outside = !res_next.distance[24] && (res_next.distance != '0);
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld_q[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= res_next;
    end
  end

endmodule

// ----- rtl/sdfp_eval.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdfp_eval
// One distance evaluation of the selected primitive: squares, a first root
// (full length or the xz radius), a second root for torus and cylinder, and
// the final combine.
// ----------------------------------------------------------------------------
module sdfp_eval #(
  parameter int STEPS = 2
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  sdfp_pkg::shape_t                    shape,
  input  logic                                in_valid,
  input  logic signed [sdfp_pkg::COORD_W-1:0] x,
  input  logic signed [sdfp_pkg::COORD_W-1:0] y,
  input  logic signed [sdfp_pkg::COORD_W-1:0] z,
  output logic                                out_valid,
  output logic signed [sdfp_pkg::DIST_W-1:0]  sdist
);

  import sdfp_pkg::*;

  localparam int A_W    = 25;
  localparam int SIDE1W = COORD_W + DIST_W;

  // Stage 1: magnitudes, box offsets and the box inner term.
  logic [MAG_W-1:0]         mx, my, mz, u_c, v_c, w_c;
  logic signed [DIST_W-1:0] qx, qy, qz, qmax, inner_c;
  logic                     s1_vld;
  logic [MAG_W-1:0]         u_q, v_q, w_q;
  logic signed [COORD_W-1:0] y1_q;
  logic signed [DIST_W-1:0] inner1_q;

  always_comb begin
    mx   = coord_mag(x);
    my   = coord_mag(y);
    mz   = coord_mag(z);
    qx   = $signed({3'b000, mx}) - K_BOX_HALF;
    qy   = $signed({3'b000, my}) - K_BOX_HALF;
    qz   = $signed({3'b000, mz}) - K_BOX_HALF;
    qmax = (qx > qy) ? qx : qy;
    qmax = (qmax > qz) ? qmax : qz;
    inner_c = (qmax < 0) ? qmax : '0;
    case (shape)
      SHAPE_SPHERE: begin
        u_c = mx;
        v_c = my;
        w_c = mz;
      end
      SHAPE_BOX: begin
        u_c = (qx > 0) ? qx[MAG_W-1:0] : '0;
        v_c = (qy > 0) ? qy[MAG_W-1:0] : '0;
        w_c = (qz > 0) ? qz[MAG_W-1:0] : '0;
      end
      default: begin
        u_c = mx;
        v_c = '0;
        w_c = mz;
      end
    endcase
  end

  // Stage 2: squares. Stage 3: radicand sum.
  logic                      s2_vld, s3_vld;
  logic [2*MAG_W-1:0]        su_q, sv_q, sw_q;
  logic signed [COORD_W-1:0] y2_q, y3_q;
  logic signed [DIST_W-1:0]  inner2_q, inner3_q;
  logic [2*MAG_W+1:0]        rad1_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_valid;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_q      <= u_c;
      v_q      <= v_c;
      w_q      <= w_c;
      y1_q     <= y;
      inner1_q <= inner_c;
      su_q     <= u_q * u_q;
      sv_q     <= v_q * v_q;
      sw_q     <= w_q * w_q;
      y2_q     <= y1_q;
      inner2_q <= inner1_q;
      rad1_q   <= (2*MAG_W+2)'(su_q) + (2*MAG_W+2)'(sv_q) + (2*MAG_W+2)'(sw_q);
      y3_q     <= y2_q;
      inner3_q <= inner2_q;
    end
  end

  // First root.
  logic                      r1_vld;
  logic [MAG_W:0]            l1;
  logic [SIDE1W-1:0]         side1;
  logic signed [COORD_W-1:0] yr;
  logic signed [DIST_W-1:0]  innerr;

  sdfp_sqrt #(
    .RAD_W (2*MAG_W+2),
    .SIDE_W(SIDE1W),
    .STEPS (STEPS)
  ) u_root1 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s3_vld),
    .radicand (rad1_q),
    .in_side  ({y3_q, inner3_q}),
    .out_valid(r1_vld),
    .root     (l1),
    .out_side (side1)
  );

  assign {yr, innerr} = side1;

  // Middle stage: operands of the second root and the partial distance.
  logic signed [DIST_W-1:0] l1s, t, tm, dx, dy, dmax, pre_c;
  logic [MAG_W-1:0]         ym;
  logic [A_W-1:0]           a_c;
  logic [MAG_W-1:0]         b_c;

  always_comb begin
    l1s  = $signed({2'b00, l1});
    ym   = coord_mag(yr);
    t    = l1s - K_TOR_MAJOR;
    tm   = t[DIST_W-1] ? -t : t;
    dx   = l1s - K_CYL_RAD;
    dy   = $signed({3'b000, ym}) - K_CYL_HALF;
    dmax = (dx > dy) ? dx : dy;
    case (shape)
      SHAPE_SPHERE: begin
        a_c   = '0;
        b_c   = '0;
        pre_c = l1s - K_R_SPHERE;
      end
      SHAPE_BOX: begin
        a_c   = '0;
        b_c   = '0;
        pre_c = l1s + innerr - K_BOX_ROUND;
      end
      SHAPE_TORUS: begin
        a_c   = tm[A_W-1:0];
        b_c   = ym;
        pre_c = -K_TOR_MINOR;
      end
      default: begin
        a_c   = (dx > 0) ? dx[A_W-1:0] : '0;
        b_c   = (dy > 0) ? dy[MAG_W-1:0] : '0;
        pre_c = (dmax < 0) ? dmax : '0;
      end
    endcase
  end

  logic                     m1_vld, m2_vld, m3_vld;
  logic [A_W-1:0]           a_q;
  logic [MAG_W-1:0]         b_q;
  logic [2*A_W-1:0]         sa_q;
  logic [2*MAG_W-1:0]       sb_q;
  logic [2*A_W+1:0]         rad2_q;
  logic signed [DIST_W-1:0] pre1_q, pre2_q, pre3_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
      m2_vld <= 1'b0;
      m3_vld <= 1'b0;
    end else if (en) begin
      m1_vld <= r1_vld;
      m2_vld <= m1_vld;
      m3_vld <= m2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_q    <= a_c;
      b_q    <= b_c;
      pre1_q <= pre_c;
      sa_q   <= a_q * a_q;
      sb_q   <= b_q * b_q;
      pre2_q <= pre1_q;
      rad2_q <= (2*A_W+2)'(sa_q) + (2*A_W+2)'(sb_q);
      pre3_q <= pre2_q;
    end
  end

  // Second root.
  logic                     r2_vld;
  logic [A_W:0]             l2;
  logic signed [DIST_W-1:0] prer;

  sdfp_sqrt #(
    .RAD_W (2*A_W+2),
    .SIDE_W(DIST_W),
    .STEPS (STEPS)
  ) u_root2 (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (m3_vld),
    .radicand (rad2_q),
    .in_side  (pre3_q),
    .out_valid(r2_vld),
    .root     (l2),
    .out_side (prer)
  );

  // Final combine: torus and cylinder add the second length.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= r2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (shape == SHAPE_TORUS || shape == SHAPE_CYL) begin
        sdist <= prer + $signed({1'b0, l2});
      end else begin
        sdist <= prer;
      end
    end
  end

endmodule

// ----- rtl/sdfp_grad.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdfp_grad
// Central differences of the six offset distances, their squares, and the
// pipelined root that gives the gradient length.
// ----------------------------------------------------------------------------
module sdfp_grad #(
  parameter int STEPS = 2
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [sdfp_pkg::DIST_W-1:0] sdist [sdfp_pkg::SMP_COUNT],
  output logic                               out_valid,
  output logic [sdfp_pkg::LEN_W-1:0]         len,
  output logic [2:0][sdfp_pkg::DIFF_W-1:0]   mags,
  output logic [2:0]                         signs,
  output logic signed [sdfp_pkg::DIST_W-1:0] dcenter
);

  import sdfp_pkg::*;

  localparam int SIDE_W = 3*DIFF_W + 3 + DIST_W;

  // Differences stay narrow: the distance changes by at most about two steps.
  logic signed [DIST_W-1:0] dw [3];
  logic signed [DIFF_W-1:0] dd [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dw[a] = sdist[SMP_XP + 2*a] - sdist[SMP_XP + 2*a + 1];
      dd[a] = dw[a][DIFF_W-1:0];
    end
  end

  logic                     g1_vld, g2_vld, g3_vld;
  logic [2:0][DIFF_W-1:0]   mag1_q, mag2_q, mag3_q;
  logic [2:0]               sgn1_q, sgn2_q, sgn3_q;
  logic signed [DIST_W-1:0] dc1_q, dc2_q, dc3_q;
  logic [2*DIFF_W-1:0]      sq_q [3];
  logic [2*LEN_W-1:0]       rad_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      g1_vld <= 1'b0;
      g2_vld <= 1'b0;
      g3_vld <= 1'b0;
    end else if (en) begin
      g1_vld <= in_valid;
      g2_vld <= g1_vld;
      g3_vld <= g2_vld;
    end
  end

  // Magnitudes, then squares, then the sum of squares.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        mag1_q[a] <= diff_mag(dd[a]);
        sgn1_q[a] <= dd[a][DIFF_W-1];
        sq_q[a]   <= mag1_q[a] * mag1_q[a];
      end
      dc1_q  <= sdist[SMP_CENTER];
      mag2_q <= mag1_q;
      sgn2_q <= sgn1_q;
      dc2_q  <= dc1_q;
      rad_q  <= (2*LEN_W)'(sq_q[0]) + (2*LEN_W)'(sq_q[1]) + (2*LEN_W)'(sq_q[2]);
      mag3_q <= mag2_q;
      sgn3_q <= sgn2_q;
      dc3_q  <= dc2_q;
    end
  end

  logic [SIDE_W-1:0] side_out;

  sdfp_sqrt #(
    .RAD_W (2*LEN_W),
    .SIDE_W(SIDE_W),
    .STEPS (STEPS)
  ) u_len (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (g3_vld),
    .radicand (rad_q),
    .in_side  ({mag3_q, sgn3_q, dc3_q}),
    .out_valid(out_valid),
    .root     (len),
    .out_side (side_out)
  );

  assign {mags, signs, dcenter} = side_out;

endmodule

// ----- rtl/sdf_primitive_with_gradient.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdf_primitive_with_gradient
// Signed distance and unit gradient of one of four fixed primitives.
// ----------------------------------------------------------------------------
// Usage:
//   A point beat (point_x/y/z, Q8.16) is taken on point_valid with point_stall
//   low. A result beat (distance Q9.16, grad_x/y/z Q2.14, is_outside) comes
//   out on result_valid and is taken when result_stall is low.
//   shape_write with shape_data selects the primitive: sphere, rounded box,
//   torus or capped cylinder. Write it only while no beat is in flight.
//   Seven distance pipelines run side by side: the point itself and the point
//   moved by +/-0.05 on each axis. Their differences give the gradient.
//   Throughput is one point per cycle while no result is stalled. Most depth,
//   at two root or quotient bits per stage, lies in the two chained square
//   roots per distance pipeline, the gradient root and the three dividers.
//   Reset clears all valid bits and selects the sphere.
//   When the receiver stalls a held result, the whole pipeline freezes and
//   point_stall rises in the same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`include "sdf_primitive_with_gradient_macros.svh"

module sdf_primitive_with_gradient #(
  parameter int SQRT_STEPS = sdfp_pkg::SQRT_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               shape_write,
  input  logic [1:0]         shape_data,
  input  logic               point_valid,
  output logic               point_stall,
  input  sdfp_pkg::point_t   point,
  output logic               result_valid,
  input  logic               result_stall,
  output sdfp_pkg::result_t  result
);

  import sdfp_pkg::*;

  // Primitive select register.
  shape_t shape;

  always_ff @(posedge clk) begin
    if (rst) begin
      shape <= SHAPE_SPHERE;
    end else if (shape_write) begin
      shape <= shape_t'(shape_data);
    end
  end

  // The pipeline moves unless a held result is stalled.
  logic en;
  assign en          = !(result_valid && result_stall);
  assign point_stall = !en;

  // Sample points: center, then plus and minus the step on each axis.
  logic signed [COORD_W-1:0] px, py, pz;
  logic signed [COORD_W-1:0] sx [SMP_COUNT];
  logic signed [COORD_W-1:0] sy [SMP_COUNT];
  logic signed [COORD_W-1:0] sz [SMP_COUNT];

  always_comb begin
    px = COORD_W'(point.point_x);
    py = COORD_W'(point.point_y);
    pz = COORD_W'(point.point_z);
    for (int i = 0; i < SMP_COUNT; i++) begin
      sx[i] = px;
      sy[i] = py;
      sz[i] = pz;
    end
    sx[SMP_XP]     = px + K_STEP;
    sx[SMP_XP + 1] = px - K_STEP;
    sy[SMP_XP + 2] = py + K_STEP;
    sy[SMP_XP + 3] = py - K_STEP;
    sz[SMP_XP + 4] = pz + K_STEP;
    sz[SMP_XP + 5] = pz - K_STEP;
  end

  // Seven distance pipelines in lockstep.
  logic                     ev_valid [SMP_COUNT];
  logic signed [DIST_W-1:0] ev_dist  [SMP_COUNT];

  for (genvar i = 0; i < SMP_COUNT; i++) begin : g_eval
    sdfp_eval #(
      .STEPS(SQRT_STEPS)
    ) u_eval (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .shape    (shape),
      .in_valid (point_valid),
      .x        (sx[i]),
      .y        (sy[i]),
      .z        (sz[i]),
      .out_valid(ev_valid[i]),
      .sdist    (ev_dist[i])
    );
  end

  // Gradient length.
  logic                     gr_valid;
  logic [LEN_W-1:0]         gr_len;
  logic [2:0][DIFF_W-1:0]   gr_mags;
  logic [2:0]               gr_signs;
  logic signed [DIST_W-1:0] gr_dist;

  sdfp_grad #(
    .STEPS(SQRT_STEPS)
  ) u_grad (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (ev_valid[SMP_CENTER]),
    .sdist    (ev_dist),
    .out_valid(gr_valid),
    .len      (gr_len),
    .mags     (gr_mags),
    .signs    (gr_signs),
    .dcenter  (gr_dist)
  );

  // Normalization and result register.
  sdfp_norm #(
    .STEPS(SQRT_STEPS)
  ) u_norm (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (gr_valid),
    .len      (gr_len),
    .mags     (gr_mags),
    .signs    (gr_signs),
    .sdist    (gr_dist),
    .out_valid(result_valid),
    .result   (result)
  );

  // Checks.
  `SDFP_ASSERT_IMP(a_outside, result_valid, result.is_outside == (!result.distance[24] && |result.distance))
  `SDFP_ASSERT_IMP(a_grad_x, result_valid, result.grad_x <= 16'sd16384 && result.grad_x >= -16'sd16384)
  `SDFP_ASSERT_IMP(a_stall_held, point_stall, result_valid)
  `SDFP_ASSERT_IMP(a_rst_clear, $past(rst), !result_valid)

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for sdf_primitive_with_gradient
// Sends points to each of the four primitives, directed corners first and then
// random points near the surfaces and across the full range. Every result beat
// is checked field by field against a 64-bit distance and gradient predictor.
// ----------------------------------------------------------------------------
module testbench;
  import sdfp_pkg::*;

  localparam int DRAIN_CYCLES = 70;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    shape_write = 1'b0;
  logic [1:0] shape_data = '0;
  logic    point_valid = 1'b0;
  logic    point_stall;
  point_t  point = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  shape_t  cur_shape = SHAPE_SPHERE;
  result_t expected_results[$];
  int      mismatches = 0;
  int      points_sent = 0;
  int      results_checked = 0;
  bit      stall_enable = 1'b0;
  int      stall_left = 0;

  sdf_primitive_with_gradient i_dut (
    .clk         (clk),
    .rst         (rst),
    .shape_write (shape_write),
    .shape_data  (shape_data),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .point       (point),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  always #4 clk = ~clk;

  // Integer square root, floor.
  function automatic longint unsigned root64(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned square(input longint v);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    return m * m;
  endfunction

  function automatic longint hyp2(input longint a, input longint b);
    return longint'(root64(square(a) + square(b)));
  endfunction

  function automatic longint hyp3(input longint a, input longint b, input longint c);
    return longint'(root64(square(a) + square(b) + square(c)));
  endfunction

  function automatic longint max0(input longint a, input longint b);
    return (a > b) ? a : b;
  endfunction

  function automatic longint min0(input longint a, input longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint absv(input longint a);
    return (a < 0) ? -a : a;
  endfunction

  // Signed distance from a Q.16 point to the selected primitive.
  function automatic longint shape_distance(input shape_t s, input longint x,
                                            input longint y, input longint z);
    longint qx, qy, qz, a, b;
    case (s)
      SHAPE_SPHERE: begin
        return hyp3(x, y, z) - 196608;
      end
      SHAPE_BOX: begin
        qx = absv(x) - 157286;
        qy = absv(y) - 157286;
        qz = absv(z) - 157286;
        a = hyp3(max0(qx, 0), max0(qy, 0), max0(qz, 0));
        b = min0(max0(qx, max0(qy, qz)), 0);
        return a + b - 26214;
      end
      SHAPE_TORUS: begin
        qx = hyp2(x, z) - 163840;
        return hyp2(qx, y) - 65536;
      end
      default: begin
        a = hyp2(x, z) - 131072;
        b = absv(y) - 170394;
        return min0(max0(a, b), 0) + hyp2(max0(a, 0), max0(b, 0));
      end
    endcase
  endfunction

  function automatic logic signed [15:0] unit_part(input longint d,
                                                   input longint unsigned len);
    longint unsigned q;
    if (len == 0) return '0;
    q = (((d < 0) ? -d : d) * 16384) / len;
    return (d < 0) ? -q[15:0] : q[15:0];
  endfunction

  // Expected result beat for one point under the current shape.
  function automatic result_t surface_result(input shape_t s, input point_t p);
    longint x, y, z, d, gx, gy, gz;
    longint unsigned gl;
    result_t r;
    x = longint'(p.point_x);
    y = longint'(p.point_y);
    z = longint'(p.point_z);
    d  = shape_distance(s, x, y, z);
    gx = shape_distance(s, x + 3277, y, z) - shape_distance(s, x - 3277, y, z);
    gy = shape_distance(s, x, y + 3277, z) - shape_distance(s, x, y - 3277, z);
    gz = shape_distance(s, x, y, z + 3277) - shape_distance(s, x, y, z - 3277);
    gl = root64(square(gx) + square(gy) + square(gz));
    if (d > 16777215) d = 16777215;
    if (d < -16777216) d = -16777216;
    r.distance   = d[24:0];
    r.grad_x     = unit_part(gx, gl);
    r.grad_y     = unit_part(gy, gl);
    r.grad_z     = unit_part(gz, gl);
    r.is_outside = (d > 0);
    return r;
  endfunction

  // Mostly short idle stretches, a few long ones.
  function automatic int idle_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  // Send one point beat and record its expected result at acceptance.
  task automatic send_point(input point_t p, input bit idle);
    int gap;
    point <= p;
    point_valid <= 1'b1;
    do @(posedge clk); while (point_stall);
    expected_results.push_back(surface_result(cur_shape, p));
    points_sent++;
    gap = idle ? idle_len() : 0;
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap > 0) begin
      point_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Let the pipeline empty; write_shape then changes the shape register.
  task automatic drain_pipe();
    point_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_shape(input shape_t s);
    drain_pipe();
    shape_write <= 1'b1;
    shape_data <= s;
    @(posedge clk);
    cur_shape = s;
    shape_write <= 1'b0;
  endtask

  function automatic point_t mk_point(input int x, input int y, input int z);
    point_t p;
    p.point_x = x[23:0];
    p.point_y = y[23:0];
    p.point_z = z[23:0];
    return p;
  endfunction

  function automatic logic [23:0] rand_coord();
    case ($urandom_range(0, 9))
      0, 1:    return 24'($urandom());
      2:       return 24'($urandom_range(0, 8191) - 4096);
      default: return 24'($urandom_range(0, 786432) - 393216);
    endcase
  endfunction

  // Origin, surface points, and both ends of the coordinate range.
  task automatic test_directed();
    shape_t s;
    for (int k = 0; k < 4; k++) begin
      s = shape_t'(k);
      write_shape(s);
      send_point(mk_point(0, 0, 0), 1'b0);
      send_point(mk_point(8388607, 8388607, 8388607), 1'b0);
      send_point(mk_point(-8388608, -8388608, -8388608), 1'b0);
      send_point(mk_point(8388607, -8388608, 0), 1'b1);
      send_point(mk_point(196608, 0, 0), 1'b0);
      send_point(mk_point(0, 170394, 163840), 1'b1);
    end
  endtask

  // Random points for each shape, with the receiver stalling at random.
  task automatic test_random(input int per_shape);
    int order[5] = '{3, 1, 0, 2, 3};
    stall_enable = 1'b1;
    foreach (order[i]) begin
      write_shape(shape_t'(order[i]));
      for (int n = 0; n < per_shape; n++)
        send_point(mk_point(rand_coord(), rand_coord(), rand_coord()),
                   ($urandom_range(0, 3) != 0));
    end
  endtask

  // The sender holds off until every outstanding result has come back.
  task automatic test_hold_off();
    for (int n = 0; n < 20; n++)
      send_point(mk_point(rand_coord(), rand_coord(), rand_coord()), 1'b0);
    drain_pipe();
    for (int n = 0; n < 20; n++)
      send_point(mk_point(rand_coord(), rand_coord(), rand_coord()), 1'b1);
  endtask

  // Receiver stall pattern.
  always @(posedge clk) begin
    if (!stall_enable) begin
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      result_stall <= 1'b1;
    end else if ($urandom_range(0, 9) < 3) begin
      stall_left <= idle_len();
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Compare each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no point outstanding");
        mismatches++;
      end else begin
        exp_r = expected_results.pop_front();
        results_checked++;
        if (result.distance !== exp_r.distance) begin
          $error("distance: expected %0d, actual %0d", exp_r.distance, result.distance);
          mismatches++;
        end
        if (result.grad_x !== exp_r.grad_x) begin
          $error("grad_x: expected %0d, actual %0d", exp_r.grad_x, result.grad_x);
          mismatches++;
        end
        if (result.grad_y !== exp_r.grad_y) begin
          $error("grad_y: expected %0d, actual %0d", exp_r.grad_y, result.grad_y);
          mismatches++;
        end
        if (result.grad_z !== exp_r.grad_z) begin
          $error("grad_z: expected %0d, actual %0d", exp_r.grad_z, result.grad_z);
          mismatches++;
        end
        if (result.is_outside !== exp_r.is_outside) begin
          $error("is_outside: expected %0d, actual %0d", exp_r.is_outside,
                 result.is_outside);
          mismatches++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(160);
    test_hold_off();
    drain_pipe();
    if (expected_results.size() != 0) mismatches++;
    $display("Sent %0d points over all four shapes, checked %0d result beats.",
             points_sent, results_checked);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // Overall time limit.
  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- sdf_primitive_with_gradient.f -----
+incdir+rtl
rtl/sdfp_pkg.sv
rtl/sdfp_sqrt.sv
rtl/sdfp_norm.sv
rtl/sdfp_eval.sv
rtl/sdfp_grad.sv
rtl/sdf_primitive_with_gradient.sv
dv/testbench.sv
